### rtl/lzss_window_decompressor_defines.svh
// Assertion macros for the LZSS window decompressor.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH
`define LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LZSSWD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LZSSWD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZSSWD_ASSERT_IMP(label, ante, cons, msg)
`define LZSSWD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### rtl/lzsswd_pkg.sv
`default_nettype none

package lzsswd_pkg;

    localparam int WIN_SIZE = 4096;
    localparam int WIN_AW   = $clog2(WIN_SIZE);
    localparam int FILL_W   = WIN_AW + 1;

    // first window slot written after a stream start
    localparam logic [WIN_AW-1:0] START_INDEX = WIN_AW'(WIN_SIZE - 18);
    localparam logic [7:0]        BLANK_BYTE  = 8'h20;
    localparam logic [4:0]        LEN_BIAS    = 5'd3;

    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } win_req_t;

endpackage

`default_nettype wire

### rtl/lzss_window_decompressor.sv
// Channel   Dir  Payload                      Transfer
// -------   ---  ---------------------------  --------------------------
// s_*       in   tdata: in_byte, tuser: start  s_tvalid && s_tready
// m_*       out  tdata: out_byte, tlast: last  m_tvalid && m_tready
//
// Header, flag, offset-low and literal bytes are handled in their accept
// cycle; any input byte waits while a result sits unaccepted in the output
// register. A match token runs the copy sequencer over the single-port window
// memory: each copied byte takes a read step (S_RD), then an emit and
// write-back step (S_EMIT) that waits for a free output register, for len in
// 3..18 copied bytes. No item is taken while a copy runs. Reset leaves the
// decoder idle; a start transfer clears it with no sweep of the window, since
// a fill count marks which slots have been written.
`default_nettype none
`include "lzss_window_decompressor_defines.svh"

module lzss_window_decompressor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic [0:0] s_tuser,   // [0] stream_start
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_stream
);

    localparam int AW = lzsswd_pkg::WIN_AW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // token phase: shift then flag or token, token right after a flag load,
    // or waiting for the second byte of a match
    typedef enum logic [1:0] {
        PH_SHIFT  = 2'd0,
        PH_LOADED = 2'd1,
        PH_MATCH  = 2'd2
    } phase_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [2:0]           hdr_reg, hdr_next;
    logic [8:0]           flag_reg, flag_next;
    logic [31:0]          rem_reg, rem_next;
    logic [7:0]           off_low_reg, off_low_next;
    logic [AW-1:0]        wi_reg, wi_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    lzsswd_pkg::win_req_t win_req;
    logic [7:0]           win_rd_data;

    logic                 accept;
    logic                 out_free;
    logic                 emit_en;
    logic [7:0]           emit_byte;
    logic [31:0]          rem_dec;
    logic                 emit_last;
    logic [31:0]          rem_hdr;
    logic [8:0]           fs;

    lzsswd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .rd_data (win_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Shared count unit: every emitted byte passes through this decrement.
    assign rem_dec   = rem_reg - 32'd1;
    assign emit_last = (rem_dec == 32'd0);

    // Header bytes land in their byte lane, little endian.
    assign rem_hdr = rem_reg | ({24'd0, s_tdata} << {hdr_reg[1:0], 3'b000});

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        done_next      = done_reg;
        hdr_next       = hdr_reg;
        flag_next      = flag_reg;
        rem_next       = rem_reg;
        off_low_next   = off_low_reg;
        wi_next        = wi_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        emit_en        = 1'b0;
        emit_byte      = s_tdata;
        fs             = flag_reg;

        win_req         = '0;
        win_req.wr_addr = wi_reg;
        win_req.wr_data = s_tdata;
        win_req.rd_addr = rd_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0])
                    begin
                        // restart: this byte is header byte zero
                        win_req.clear = 1'b1;
                        done_next     = 1'b0;
                        hdr_next      = 3'd1;
                        rem_next      = {24'd0, s_tdata};
                        wi_next       = lzsswd_pkg::START_INDEX;
                        flag_next     = '0;
                        phase_next    = PH_SHIFT;
                        off_low_next  = '0;
                    end
                    else if (!done_reg)
                    begin
                        if (!hdr_reg[2])
                        begin
                            rem_next = rem_hdr;
                            hdr_next = hdr_reg + 3'd1;
                            if ((hdr_reg == 3'd3) && (rem_hdr == 32'd0))
                            begin
                                done_next = 1'b1;
                            end
                        end
                        else if (phase_reg == PH_MATCH)
                        begin
                            // second match byte: launch the copy
                            rd_ptr_next = {s_tdata[7:4], off_low_reg};
                            cnt_next    = {1'b0, s_tdata[3:0]} + lzsswd_pkg::LEN_BIAS;
                            phase_next  = PH_SHIFT;
                            state_next  = S_RD;
                        end
                        else
                        begin
                            if (phase_reg == PH_SHIFT)
                            begin
                                fs = {1'b0, flag_reg[8:1]};
                            end
                            if ((phase_reg == PH_SHIFT) && (fs[8:1] == 8'd0))
                            begin
                                // marker bit ran out: this is a flag byte
                                flag_next  = {1'b1, s_tdata};
                                phase_next = PH_LOADED;
                            end
                            else
                            begin
                                flag_next = fs;
                                if (fs[0])
                                begin
                                    phase_next    = PH_SHIFT;
                                    emit_en       = 1'b1;
                                    win_req.wr_en = 1'b1;
                                    wi_next       = wi_reg + AW'(1);
                                end
                                else
                                begin
                                    off_low_next = s_tdata;
                                    phase_next   = PH_MATCH;
                                end
                            end
                        end
                    end
                end
            end
            S_RD:
            begin
                win_req.rd_en = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the fetched byte until the output register frees up
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    emit_byte = win_rd_data;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        win_req.wr_en   = 1'b1;
                        win_req.wr_data = win_rd_data;
                        wi_next         = wi_reg + AW'(1);
                        rd_ptr_next     = rd_ptr_reg + AW'(1);
                        cnt_next        = cnt_reg - 5'd1;
                        state_next      = (cnt_reg == 5'd1) ? S_IDLE : S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            rem_next       = rem_dec;
            if (emit_last)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SHIFT;
            done_reg      <= 1'b1;
            hdr_reg       <= '0;
            flag_reg      <= '0;
            rem_reg       <= '0;
            wi_reg        <= lzsswd_pkg::START_INDEX;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            done_reg      <= done_next;
            hdr_reg       <= hdr_next;
            flag_reg      <= flag_next;
            rem_reg       <= rem_next;
            wi_reg        <= wi_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_low_reg  <= off_low_next;
        rd_ptr_reg   <= rd_ptr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // a running copy never has an empty byte count
    `LZSSWD_ASSERT_IMP(a_copy_cnt_nonzero, (state_reg == S_RD), (cnt_reg != 5'd0), "copy with zero count")
    // no copy runs on a finished stream
    `LZSSWD_ASSERT_IMP(a_copy_not_done, (state_reg != S_IDLE), (!done_reg), "copy after stream end")
    // a byte marked last always leaves the decoder finished
    `LZSSWD_ASSERT_IMP(a_last_sets_done, (m_tvalid && m_tlast), (done_reg), "last byte without done")
    // a read is always followed by the emit step
    `LZSSWD_ASSERT_NXT(a_rd_then_emit, (state_reg == S_RD), (state_reg == S_EMIT), "read not followed by emit")

endmodule

`default_nettype wire

### rtl/lzsswd_window.sv
`default_nettype none

module lzsswd_window (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lzsswd_pkg::win_req_t      req,
    output logic [7:0]                     rd_data
);

    logic [7:0]                     mem [lzsswd_pkg::WIN_SIZE];
    logic [7:0]                     rd_q_reg;
    logic                           hit_reg;
    logic [lzsswd_pkg::FILL_W-1:0]  fill_reg;
    logic [lzsswd_pkg::FILL_W-1:0]  fill_next;
    logic [lzsswd_pkg::WIN_AW-1:0]  rel;
    logic                           hit;

    // Slots are written in order from START_INDEX; anything beyond the fill
    // count has not been written since the stream start and reads as blank.
    assign rel = req.rd_addr - lzsswd_pkg::START_INDEX;
    assign hit = ({1'b0, rel} < fill_reg);

    always_comb
    begin
        fill_next = fill_reg;
        if (req.clear)
        begin
            fill_next = '0;
        end
        else if (req.wr_en && (fill_reg != lzsswd_pkg::FILL_W'(lzsswd_pkg::WIN_SIZE)))
        begin
            fill_next = fill_reg + lzsswd_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
            hit_reg  <= hit;
        end
    end

    assign rd_data = hit_reg ? rd_q_reg : lzsswd_pkg::BLANK_BYTE;

endmodule

`default_nettype wire
